[hw/rtl/sha256_nonce_search_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the nonce search block
// Concurrent checks that can all be removed by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SHA256_NONCE_SEARCH_TOP_MACROS_SVH
`define SHA256_NONCE_SEARCH_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked at every rising edge outside reset.
`define SNS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication checked outside reset.
`define SNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SNS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/sns_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 nonce search package
// Payload types, hash constants and round functions.
// ----------------------------------------------------------------------------
package sns_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] hash_t;
    typedef word_t [15:0] window_t;

    typedef struct packed {
        logic [31:0] prev_word0;
        logic [31:0] prev_word1;
        logic [31:0] prev_word2;
        logic [31:0] prev_word3;
        logic [31:0] prev_word4;
        logic [31:0] prev_word5;
        logic [31:0] prev_word6;
        logic [31:0] prev_word7;
        logic [31:0] block_index;
    } job_t;

    typedef struct packed {
        logic [31:0] hash_word0;
        logic [31:0] hash_word1;
        logic [31:0] hash_word2;
        logic [31:0] hash_word3;
        logic [31:0] hash_word4;
        logic [31:0] hash_word5;
        logic [31:0] hash_word6;
        logic [31:0] hash_word7;
        logic [31:0] found_nonce;
        logic        exhausted;
    } result_t;

    // Output of the hash pipeline, one trial per cycle.
    typedef struct packed {
        logic        vld;
        logic [31:0] nonce;
        hash_t       digest;
    } pipe_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    localparam int unsigned ROUNDS   = 64;
    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [31:0] MSG_BITS = 32'd320;
    localparam logic [3:0]  DIFF_MAX = 4'd8;
    localparam logic [3:0]  DIFF_RST = 4'd3;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sig0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sig1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t sml_sig0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t sml_sig1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    // Mask of the digest bits that must be zero; difficulty saturates at eight.
    function automatic word_t diff_mask(input logic [3:0] d);
        logic [3:0] sat;
        logic [5:0] shamt;
        sat   = (d > DIFF_MAX) ? DIFF_MAX : d;
        shamt = 6'd32 - {sat, 2'b00};
        if (sat == 4'd0)
        begin
            return '0;
        end
        return 32'hffff_ffff << shamt;
    endfunction

endpackage

[hw/rtl/sns_pipe.sv]
// ----------------------------------------------------------------------------
// SHA-256 hash pipeline
// One round per stage over 64 stages plus a load and a final add stage.
// ----------------------------------------------------------------------------
module sns_pipe
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                flush,
    input  logic                issue,
    input  sns_pkg::job_t       job,
    input  logic [31:0]         nonce,
    output sns_pkg::pipe_out_t  pout
);

    localparam int unsigned R = sns_pkg::ROUNDS;

    sns_pkg::hash_t   st_v_reg [0:R];
    sns_pkg::window_t st_w_reg [0:R];
    logic [31:0]      st_n_reg [0:R];
    logic [R:0]       st_vld_reg;

    sns_pkg::hash_t   dig_reg;
    logic [31:0]      dig_n_reg;
    logic             dig_vld_reg;

    // Load stage: initial state and the padded message block.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            st_v_reg[0][i] <= sns_pkg::INIT_H[i];
        end
        st_w_reg[0][0]  <= job.prev_word0;
        st_w_reg[0][1]  <= job.prev_word1;
        st_w_reg[0][2]  <= job.prev_word2;
        st_w_reg[0][3]  <= job.prev_word3;
        st_w_reg[0][4]  <= job.prev_word4;
        st_w_reg[0][5]  <= job.prev_word5;
        st_w_reg[0][6]  <= job.prev_word6;
        st_w_reg[0][7]  <= job.prev_word7;
        st_w_reg[0][8]  <= job.block_index;
        st_w_reg[0][9]  <= nonce;
        st_w_reg[0][10] <= sns_pkg::PAD_WORD;
        st_w_reg[0][11] <= '0;
        st_w_reg[0][12] <= '0;
        st_w_reg[0][13] <= '0;
        st_w_reg[0][14] <= '0;
        st_w_reg[0][15] <= sns_pkg::MSG_BITS;
        st_n_reg[0]     <= nonce;
    end

    for (genvar s = 0; s < R; s++)
    begin : g_round
        sns_pkg::word_t t1;
        sns_pkg::word_t t2;
        sns_pkg::word_t w_new;
        sns_pkg::hash_t v;
        sns_pkg::window_t w;

        assign v  = st_v_reg[s];
        assign w  = st_w_reg[s];
        assign t1 = v[7] + sns_pkg::big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
                    + sns_pkg::ROUND_K[s] + w[0];
        assign t2 = sns_pkg::big_sig0(v[0])
                    + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        assign w_new = w[0] + sns_pkg::sml_sig0(w[1]) + w[9] + sns_pkg::sml_sig1(w[14]);

        always_ff @(posedge clk)
        begin
            st_v_reg[s+1][0] <= t1 + t2;
            st_v_reg[s+1][1] <= v[0];
            st_v_reg[s+1][2] <= v[1];
            st_v_reg[s+1][3] <= v[2];
            st_v_reg[s+1][4] <= v[3] + t1;
            st_v_reg[s+1][5] <= v[4];
            st_v_reg[s+1][6] <= v[5];
            st_v_reg[s+1][7] <= v[6];
            for (int i = 0; i < 15; i++)
            begin
                st_w_reg[s+1][i] <= w[i+1];
            end
            st_w_reg[s+1][15] <= w_new;
            st_n_reg[s+1]     <= st_n_reg[s];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            dig_reg[i] <= sns_pkg::INIT_H[i] + st_v_reg[R][i];
        end
        dig_n_reg <= st_n_reg[R];
    end

    // Valid bits travel with the trials; a flush drops everything in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg  <= '0;
            dig_vld_reg <= 1'b0;
        end
        else if (flush)
        begin
            st_vld_reg  <= '0;
            dig_vld_reg <= 1'b0;
        end
        else
        begin
            st_vld_reg  <= {st_vld_reg[R-1:0], issue};
            dig_vld_reg <= st_vld_reg[R];
        end
    end

    assign pout.vld    = dig_vld_reg;
    assign pout.nonce  = dig_n_reg;
    assign pout.digest = dig_reg;

endmodule

[hw/rtl/sha256_nonce_search_top.sv]
// ----------------------------------------------------------------------------
// SHA-256 proof-of-work nonce search
// Hashes a job's 40-byte message for nonces 0, 1, 2, ... and returns the
// first digest that meets the difficulty, or an exhausted flag.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  job       in         job_valid / job_stall   sns_pkg::job_t
//  res       out        res_valid / res_stall   sns_pkg::result_t
//  cfg       in         cfg_wr_en               cfg_wr_data (difficulty, 4 bits)
//
// The time from a job's transfer to its result grows with the winning
// nonce and is longest when all 2^32 nonces fail. The 66-stage hash
// pipeline starts one nonce per cycle.
// Reset is asynchronous and active low; difficulty resets to three.
// One job is searched at a time: job_stall stays high from the transfer of a
// job until its result has been transferred. res_stall only holds the result.
// ----------------------------------------------------------------------------
`include "sha256_nonce_search_top_macros.svh"

module sha256_nonce_search_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_stall,
    input  sns_pkg::job_t      job,
    output logic               res_valid,
    input  logic               res_stall,
    output sns_pkg::result_t   res,
    input  logic               cfg_wr_en,
    input  logic [3:0]         cfg_wr_data
);

    sns_pkg::state_t    state_reg, state_next;
    sns_pkg::job_t      job_reg;
    sns_pkg::result_t   res_reg, res_next;
    logic [3:0]         diff_reg;
    logic [31:0]        nonce_reg;
    logic               issue_done_reg;
    logic               issue;
    logic               flush;
    logic               hit;
    logic               last;
    sns_pkg::word_t     mask;
    sns_pkg::pipe_out_t pout;

    assign mask = sns_pkg::diff_mask(diff_reg);

    // The user must write the difficulty register only between jobs; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg <= sns_pkg::DIFF_RST;
        end
        else if (cfg_wr_en)
        begin
            diff_reg <= cfg_wr_data;
        end
    end

    // Nonces enter the pipeline one per cycle during a search, until all 2^32 have gone in or a hit ends it.
    assign issue = (state_reg == sns_pkg::ST_RUN) && !issue_done_reg;

    sns_pipe u_pipe
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flush (flush),
        .issue (issue),
        .job   (job_reg),
        .nonce (nonce_reg),
        .pout  (pout)
    );

    // Trials leave the pipeline in nonce order, so the first hit seen is
    // the smallest qualifying nonce.
    assign hit  = pout.vld && ((pout.digest[0] & mask) == 32'd0);
    assign last = pout.vld && (pout.nonce == 32'hffff_ffff);

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        flush      = 1'b0;
        unique case (state_reg)
            sns_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = sns_pkg::ST_RUN;
                end
            end
            sns_pkg::ST_RUN:
            begin
                if (hit)
                begin
                    state_next           = sns_pkg::ST_DONE;
                    flush                = 1'b1;
                    res_next.hash_word0  = pout.digest[0];
                    res_next.hash_word1  = pout.digest[1];
                    res_next.hash_word2  = pout.digest[2];
                    res_next.hash_word3  = pout.digest[3];
                    res_next.hash_word4  = pout.digest[4];
                    res_next.hash_word5  = pout.digest[5];
                    res_next.hash_word6  = pout.digest[6];
                    res_next.hash_word7  = pout.digest[7];
                    res_next.found_nonce = pout.nonce;
                    res_next.exhausted   = 1'b0;
                end
                else if (last)
                begin
                    // Every nonce failed: the result carries zeros.
                    state_next         = sns_pkg::ST_DONE;
                    flush              = 1'b1;
                    res_next           = '0;
                    res_next.exhausted = 1'b1;
                end
            end
            sns_pkg::ST_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = sns_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sns_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sns_pkg::ST_IDLE;
            nonce_reg      <= '0;
            issue_done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sns_pkg::ST_IDLE)
            begin
                nonce_reg      <= '0;
                issue_done_reg <= 1'b0;
            end
            else if (issue)
            begin
                nonce_reg <= nonce_reg + 32'd1;
                if (nonce_reg == 32'hffff_ffff)
                begin
                    issue_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (job_valid && !job_stall)
        begin
            job_reg <= job;
        end
    end

    assign job_stall = (state_reg != sns_pkg::ST_IDLE);
    assign res_valid = (state_reg == sns_pkg::ST_DONE);
    assign res       = res_reg;

    `SNS_ASSERT_IMP(a_exh_zero, clk, rst_n, res_valid && res.exhausted, res.found_nonce == 32'd0 && res.hash_word0 == 32'd0, "exhausted result carries nonzero fields")
    `SNS_ASSERT_IMP(a_hit_mask, clk, rst_n, res_valid && !res.exhausted, (res.hash_word0 & mask) == 32'd0, "found digest misses the difficulty")
    `SNS_ASSERT_NXT(a_job_start, clk, rst_n, job_valid && !job_stall, state_reg == sns_pkg::ST_RUN && nonce_reg == 32'd0, "search did not start at nonce zero")
    `SNS_ASSERT_IMP(a_no_issue, clk, rst_n, state_reg != sns_pkg::ST_RUN, !issue, "nonce issued outside a search")

endmodule

[verif/tb_sha256_nonce_search_top.sv]
// ----------------------------------------------------------------------------
// Nonce search testbench
// Sends mining jobs at several difficulty settings and checks each found
// digest, nonce and exhausted flag against an in-bench SHA-256 search.
// ----------------------------------------------------------------------------
module tb_sha256_nonce_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    // This limit leaves a wide margin for unlucky searches at difficulty four.
    localparam longint CYCLE_LIMIT = 64'd6_000_000;
    localparam int     SETTLE_CYCLES = 80;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               job_valid = 1'b0;
    logic               job_stall;
    sns_pkg::job_t      job = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    sns_pkg::result_t   res;
    logic               cfg_wr_en = 1'b0;
    logic [3:0]         cfg_wr_data = 4'd0;

    // Jobs waiting to be sent and digests waiting to come back.
    sns_pkg::job_t      job_backlog[$];
    sns_pkg::result_t   digest_queue[$];

    // Predictor's copy of the difficulty register.
    logic [3:0] model_difficulty = 4'd3;

    int         mismatches = 0;
    longint     cycles = 0;

    // Burst and gap counters for the sender; run counter for the receiver.
    int         burst_left = 0;
    int         gap_left = 0;
    int         stall_left = 0;

    sha256_nonce_search_top uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_stall   (job_stall),
        .job         (job),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // SHA-256 predictor
    // ------------------------------------------------------------------------
    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Hashes one padded 16-word block and returns the first digest word in
    // slot 0 of the result.
    function automatic void hash_block(input logic [31:0] msg [16],
                                       output logic [31:0] dig [8]);
        logic [31:0] sched [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
        begin
            sched[t] = msg[t];
        end
        for (int t = 16; t < 64; t++)
        begin
            sched[t] = sched[t-16] + sched[t-7]
                + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
                + (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10));
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = H0[i];
        end
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + sched[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            dig[i] = H0[i] + v[i];
        end
    endfunction

    // Searches nonces from zero for the first digest with enough leading
    // zero nibbles, exactly as the block is meant to.
    function automatic sns_pkg::result_t search_nonce(input sns_pkg::job_t j,
                                                      input logic [3:0] diff);
        logic [31:0]      msg [16];
        logic [31:0]      dig [8];
        logic [31:0]      zero_mask;
        logic [3:0]       sat;
        sns_pkg::result_t r;
        longint           n;
        sat = (diff > 4'd8) ? 4'd8 : diff;
        zero_mask = (sat == 4'd0) ? 32'd0 : (32'hffff_ffff << (32 - 4 * sat));
        msg = '{j.prev_word0, j.prev_word1, j.prev_word2, j.prev_word3,
                j.prev_word4, j.prev_word5, j.prev_word6, j.prev_word7,
                j.block_index, 32'd0, 32'h8000_0000, 32'd0,
                32'd0, 32'd0, 32'd0, 32'd320};
        r = '0;
        r.exhausted = 1'b1;
        for (n = 0; n < 64'h1_0000_0000; n++)
        begin
            msg[9] = n[31:0];
            hash_block(msg, dig);
            if ((dig[0] & zero_mask) == 32'd0)
            begin
                r = '{dig[0], dig[1], dig[2], dig[3], dig[4], dig[5], dig[6], dig[7],
                      n[31:0], 1'b0};
                break;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Job driver: bursts of random length separated by random gaps. A job
    // stays on the bus unchanged until its transfer. The expected digest is
    // computed at the transfer, with the difficulty in force then.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic next_valid;
        next_valid = job_valid;
        if (rst_n)
        begin
            if (job_valid && !job_stall)
            begin
                digest_queue.push_back(search_nonce(job, model_difficulty));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (job_backlog.size() > 0)
                begin
                    next_valid = 1'b1;
                    job <= job_backlog.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        // Roughly a third of the bursts run with no gap.
                        burst_left = $urandom_range(0, 4);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
            end
            job_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and stall pattern. The receiver alternates runs of
    // stalling and not stalling, with an occasional long open stretch.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sns_pkg::result_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (digest_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result transfer: %h", res);
                    end
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (res.hash_word0 !== want.hash_word0
                        || res.hash_word1 !== want.hash_word1
                        || res.hash_word2 !== want.hash_word2
                        || res.hash_word3 !== want.hash_word3
                        || res.hash_word4 !== want.hash_word4
                        || res.hash_word5 !== want.hash_word5
                        || res.hash_word6 !== want.hash_word6
                        || res.hash_word7 !== want.hash_word7
                        || res.found_nonce !== want.found_nonce
                        || res.exhausted !== want.exhausted)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result mismatch: expected %h nonce %h exh %b",
                                     {want.hash_word0, want.hash_word1, want.hash_word2,
                                      want.hash_word3, want.hash_word4, want.hash_word5,
                                      want.hash_word6, want.hash_word7},
                                     want.found_nonce, want.exhausted);
                            $display("                 actual   %h nonce %h exh %b",
                                     {res.hash_word0, res.hash_word1, res.hash_word2,
                                      res.hash_word3, res.hash_word4, res.hash_word5,
                                      res.hash_word6, res.hash_word7},
                                     res.found_nonce, res.exhausted);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        res_stall <= 1'b1;
                        stall_left = $urandom_range(1, 40);
                    end
                    1:
                    begin
                        res_stall <= 1'b0;
                        stall_left = $urandom_range(100, 400);
                    end
                    default:
                    begin
                        res_stall <= 1'($urandom_range(0, 1));
                        stall_left = $urandom_range(0, 5);
                    end
                endcase
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sha256_nonce_search_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic sns_pkg::job_t random_job();
        return '{$urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
    endfunction

    // Blocks until every job has been sent and every result has come back.
    // The queues and the valid are looked at on the falling edge, after the
    // driver and monitor have settled.
    task automatic drain();
        @(negedge clk);
        while (job_backlog.size() > 0 || job_valid || digest_queue.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Writes the difficulty register; only called while the block is idle.
    task automatic set_difficulty(input logic [3:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_difficulty = value;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [3:0] diff, input int count);
        set_difficulty(diff);
        for (int i = 0; i < count; i++)
        begin
            job_backlog.push_back(random_job());
        end
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two jobs at the reset difficulty of three, without any write.
        job_backlog.push_back('0);
        job_backlog.push_back('1);
        drain();

        // Difficulty zero accepts nonce zero at once. Field extremes and
        // alternating bit patterns go through here as well.
        set_difficulty(4'd0);
        job_backlog.push_back('0);
        job_backlog.push_back('1);
        job_backlog.push_back({9{32'haaaa_aaaa}});
        job_backlog.push_back({9{32'h5555_5555}});
        job_backlog.push_back(random_job());
        drain();

        // Difficulty eight and anything above it need a digest word that is
        // all zero, which no practical search finds. Their register values
        // are written while idle so every data bit toggles, and the search
        // at those settings is left out.
        set_difficulty(4'd15);
        set_difficulty(4'd8);
        set_difficulty(4'd9);

        set_difficulty(4'd1);
        job_backlog.push_back('0);
        job_backlog.push_back('1);
        job_backlog.push_back('{32'hffff_ffff, 32'd0, 32'hffff_ffff, 32'd0,
                                32'hffff_ffff, 32'd0, 32'hffff_ffff, 32'd0, 32'hffff_ffff});
        job_backlog.push_back(random_job());
        drain();

        set_difficulty(4'd2);
        job_backlog.push_back('0);
        job_backlog.push_back(random_job());
        job_backlog.push_back(random_job());
        drain();

        // Random part: most jobs at low difficulty so the run stays short,
        // a few at the reset value and two at difficulty four.
        run_phase(4'd1, 40);
        run_phase(4'd2, 50);
        run_phase(4'd0, 8);
        run_phase(4'd3, 25);
        run_phase(4'd4, 2);
        run_phase(4'd1, 10);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && digest_queue.size() == 0)
        begin
            $display("sha256_nonce_search_top verification clean");
        end
        else
        begin
            $display("sha256_nonce_search_top verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/sns_pkg.sv
hw/rtl/sns_pipe.sv
hw/rtl/sha256_nonce_search_top.sv
verif/tb_sha256_nonce_search_top.sv
